### hdl/ascii_decimal_to_fixed_point_assert.svh
// Assertion macros used by the checker file.
`ifndef ASCII_DECIMAL_TO_FIXED_POINT_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_POINT_ASSERT_SVH

// same-cycle implication
`define ADTF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADTF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/adtf_pkg.sv
package adtf_pkg;

  localparam int BYTE_W      = 8;
  localparam int IDX_OUT_W   = 5;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int INT_ACC_W   = 33;
  localparam int FRAC_ACC_W  = 30;
  localparam int FRAC_DIG_W  = 4;

  localparam int DEF_NUM_COEFFS      = 25;
  localparam int DEF_FRAC_BITS       = 8;
  localparam int DEF_MAX_FRAC_DIGITS = 9;

  localparam logic [BYTE_W-1:0] ASCII_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] ASCII_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] ASCII_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;

  localparam logic [INT_ACC_W-1:0] INT_CAP = 33'h1_0000_0000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHAR  = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIVIDE,
    CS_ADD,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic start;
    logic div_step;
    logic sum;
    logic finish;
  } adtf_cmd_t;

  function automatic logic [FRAC_ACC_W-1:0] pow_ten(input logic [FRAC_DIG_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

### hdl/adtf_ctrl.sv
module adtf_ctrl #(
  parameter int FRAC_BITS = adtf_pkg::DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  byte_is_lf,
  output logic                  out_valid,
  input  logic                  out_ready,
  output adtf_pkg::adtf_cmd_t   cmd
);
  import adtf_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid && byte_is_lf) state_nxt = CS_DIVIDE;
      end
      CS_DIVIDE: begin
        if (cnt_r == '0) state_nxt = CS_ADD;
      end
      CS_ADD: begin
        state_nxt = CS_EMIT;
      end
      CS_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid && !byte_is_lf;
        cmd.start     = in_valid && byte_is_lf;
      end
      CS_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      CS_ADD: begin
        cmd.sum = 1'b1;
      end
      CS_EMIT: begin
        cmd.finish = !out_valid_r || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.start) begin
      cnt_nxt = CNT_W'(FRAC_BITS);
    end else if (cmd.div_step && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/adtf_datapath.sv
module adtf_datapath #(
  parameter int NUM_COEFFS      = adtf_pkg::DEF_NUM_COEFFS,
  parameter int FRAC_BITS       = adtf_pkg::DEF_FRAC_BITS,
  parameter int MAX_FRAC_DIGITS = adtf_pkg::DEF_MAX_FRAC_DIGITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  adtf_pkg::adtf_cmd_t                   cmd,
  input  logic [adtf_pkg::BYTE_W-1:0]           in_rx_byte,
  output logic                                  byte_is_lf,
  output logic [adtf_pkg::IDX_OUT_W-1:0]        out_coeff_index,
  output logic signed [adtf_pkg::VALUE_W-1:0]   out_coeff_value,
  output logic [adtf_pkg::STATUS_W-1:0]         out_status
);
  import adtf_pkg::*;

  localparam int IDX_W  = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
  localparam int NUM_W  = FRAC_ACC_W + FRAC_BITS + 2;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int MAG_W  = INT_ACC_W + FRAC_BITS + 1;
  localparam int IPROD_W = INT_ACC_W + 4;
  localparam int FPROD_W = FRAC_ACC_W + 4;

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(33'h0_7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(33'h0_8000_0000);

  // line state
  logic [BYTE_W-1:0]     held_byte_r, held_byte_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  line_start_r, line_start_nxt;
  logic                  negative_r, negative_nxt;
  logic                  seen_point_r, seen_point_nxt;
  logic [INT_ACC_W-1:0]  int_acc_r, int_acc_nxt;
  logic [FRAC_ACC_W-1:0] frac_acc_r, frac_acc_nxt;
  logic [FRAC_DIG_W-1:0] frac_dig_r, frac_dig_nxt;
  logic                  bad_char_r, bad_char_nxt;
  logic [IDX_W-1:0]      next_idx_r, next_idx_nxt;

  // divider and result
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [NUM_W-1:0]      div_r, div_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r, out_idx_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  status_t               out_status_r, out_status_nxt;

  logic [3:0]            digit;
  logic                  is_digit;
  logic [IPROD_W-1:0]    int_prod;
  logic [FPROD_W-1:0]    frac_prod;
  logic [FRAC_ACC_W-1:0] den;
  logic                  q_bit;
  logic [MAG_W-1:0]      mag_sat;
  logic                  sat;

  assign byte_is_lf = (in_rx_byte == ASCII_LF);

  assign digit     = 4'(held_byte_r - ASCII_ZERO);
  assign is_digit  = held_byte_r inside {[ASCII_ZERO:ASCII_NINE]};
  assign int_prod  = (IPROD_W'(int_acc_r) << 3) + (IPROD_W'(int_acc_r) << 1)
                     + IPROD_W'(digit);
  assign frac_prod = (FPROD_W'(frac_acc_r) << 3) + (FPROD_W'(frac_acc_r) << 1)
                     + FPROD_W'(digit);
  assign den       = pow_ten(frac_dig_r);
  assign q_bit     = (num_r >= div_r);

  always_comb begin
    if (negative_r) begin
      sat     = (mag_r > NEG_LIM);
      mag_sat = sat ? NEG_LIM : mag_r;
    end else begin
      sat     = (mag_r > POS_LIM);
      mag_sat = sat ? POS_LIM : mag_r;
    end
  end

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    line_start_nxt = line_start_r;
    negative_nxt   = negative_r;
    seen_point_nxt = seen_point_r;
    int_acc_nxt    = int_acc_r;
    frac_acc_nxt   = frac_acc_r;
    frac_dig_nxt   = frac_dig_r;
    bad_char_nxt   = bad_char_r;
    next_idx_nxt   = next_idx_r;
    num_nxt        = num_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    mag_nxt        = mag_r;
    out_idx_nxt    = out_idx_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (cmd.take_byte) begin
      // the byte held since the last transfer is processed now
      if (held_valid_r) begin
        if (line_start_r) begin
          negative_nxt   = (held_byte_r != ASCII_PLUS);
          line_start_nxt = 1'b0;
        end else if (held_byte_r == ASCII_POINT && !seen_point_r) begin
          seen_point_nxt = 1'b1;
        end else if (!is_digit) begin
          bad_char_nxt = 1'b1;
        end else if (!seen_point_r) begin
          int_acc_nxt = (int_prod > IPROD_W'(INT_CAP)) ? INT_CAP
                                                       : int_prod[INT_ACC_W-1:0];
        end else if (frac_dig_r < FRAC_DIG_W'(MAX_FRAC_DIGITS)) begin
          frac_acc_nxt = frac_prod[FRAC_ACC_W-1:0];
          frac_dig_nxt = frac_dig_r + 1'b1;
        end
      end
      held_byte_nxt  = in_rx_byte;
      held_valid_nxt = 1'b1;
    end

    if (cmd.start) begin
      // rounded quotient: (2*frac*2^F + den) / (2*den)
      num_nxt = (NUM_W'(frac_acc_r) << (FRAC_BITS + 1)) + NUM_W'(den);
      div_nxt = NUM_W'(den) << (FRAC_BITS + 1);
      quo_nxt = '0;
    end

    if (cmd.div_step) begin
      if (q_bit) num_nxt = num_r - div_r;
      div_nxt = div_r >> 1;
      quo_nxt = QUO_W'({quo_r, q_bit});
    end

    if (cmd.sum) begin
      mag_nxt = (MAG_W'(int_acc_r) << FRAC_BITS) + MAG_W'(quo_r);
    end

    if (cmd.finish) begin
      out_idx_nxt   = IDX_OUT_W'(next_idx_r);
      out_value_nxt = negative_r ? VALUE_W'(MAG_W'(0) - mag_sat) : VALUE_W'(mag_sat);
      if (bad_char_r) begin
        out_status_nxt = STATUS_BAD_CHAR;
      end else if (sat) begin
        out_status_nxt = STATUS_SATURATED;
      end else begin
        out_status_nxt = STATUS_OK;
      end
      next_idx_nxt   = (next_idx_r == IDX_W'(NUM_COEFFS - 1)) ? '0 : next_idx_r + 1'b1;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
      line_start_nxt = 1'b1;
      negative_nxt   = 1'b0;
      seen_point_nxt = 1'b0;
      int_acc_nxt    = '0;
      frac_acc_nxt   = '0;
      frac_dig_nxt   = '0;
      bad_char_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      line_start_r <= 1'b1;
      negative_r   <= 1'b0;
      seen_point_r <= 1'b0;
      int_acc_r    <= '0;
      frac_acc_r   <= '0;
      frac_dig_r   <= '0;
      bad_char_r   <= 1'b0;
      next_idx_r   <= '0;
    end else begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      line_start_r <= line_start_nxt;
      negative_r   <= negative_nxt;
      seen_point_r <= seen_point_nxt;
      int_acc_r    <= int_acc_nxt;
      frac_acc_r   <= frac_acc_nxt;
      frac_dig_r   <= frac_dig_nxt;
      bad_char_r   <= bad_char_nxt;
      next_idx_r   <= next_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r        <= num_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    mag_r        <= mag_nxt;
    out_idx_r    <= out_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_coeff_index = out_idx_r;
  assign out_coeff_value = out_value_r;
  assign out_status      = out_status_r;

endmodule

### hdl/ascii_decimal_to_fixed_point.sv
// ASCII decimal line to signed fixed-point converter. Bytes of text lines
// (sign, integer digits, optional '.', fraction digits, CR, LF) enter on the
// in_ channel; each LF produces one transfer on the out_ channel holding the
// value times 2^FRAC_BITS rounded half away from zero, saturated to 32 bits,
// the coefficient index (0..NUM_COEFFS-1, wrapping) and a status (ok, bad
// character, saturated). Bytes other than LF are taken back to back while
// idle. After an LF no byte is taken until the rounded fraction has come
// from a restoring divider that resolves one quotient bit per cycle,
// FRAC_BITS+1 bits in all, followed by an add and an output load. The
// output register lets bytes of the next line flow in while a result
// waits; the output load of a second LF waits until that result is taken.
module ascii_decimal_to_fixed_point #(
  parameter int NUM_COEFFS      = adtf_pkg::DEF_NUM_COEFFS,
  parameter int FRAC_BITS       = adtf_pkg::DEF_FRAC_BITS,
  parameter int MAX_FRAC_DIGITS = adtf_pkg::DEF_MAX_FRAC_DIGITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [adtf_pkg::BYTE_W-1:0]           in_rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [adtf_pkg::IDX_OUT_W-1:0]        out_coeff_index,
  output logic signed [adtf_pkg::VALUE_W-1:0]   out_coeff_value,
  output logic [adtf_pkg::STATUS_W-1:0]         out_status
);
  import adtf_pkg::*;

  adtf_cmd_t cmd;
  logic      byte_is_lf;

  adtf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_is_lf (byte_is_lf),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  adtf_datapath #(
    .NUM_COEFFS      (NUM_COEFFS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_rx_byte      (in_rx_byte),
    .byte_is_lf      (byte_is_lf),
    .out_coeff_index (out_coeff_index),
    .out_coeff_value (out_coeff_value),
    .out_status      (out_status)
  );

endmodule

### hdl/adtf_checker.sv
`include "ascii_decimal_to_fixed_point_assert.svh"

module adtf_sva #(
  parameter int NUM_COEFFS = adtf_pkg::DEF_NUM_COEFFS
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [adtf_pkg::BYTE_W-1:0]           in_rx_byte,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [adtf_pkg::IDX_OUT_W-1:0]        out_coeff_index,
  input logic signed [adtf_pkg::VALUE_W-1:0]   out_coeff_value,
  input logic [adtf_pkg::STATUS_W-1:0]         out_status
);
  import adtf_pkg::*;

  // a stalled result holds
  `ADTF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_coeff_value) && $stable(out_coeff_index) && $stable(out_status), "result changed while stalled")

  // line end starts the divider, no byte taken next cycle
  `ADTF_ASSERT_NXT(a_lf_busy, clk, rst_n, in_valid && in_ready && in_rx_byte == ASCII_LF, !in_ready, "byte taken right after line end")

  `ADTF_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid, (NUM_COEFFS > 32) || (out_coeff_index < NUM_COEFFS), "coefficient index out of range")

  `ADTF_ASSERT_IMP(a_sat_value, clk, rst_n, out_valid && out_status == STATUS_SATURATED, out_coeff_value == 32'sh7FFF_FFFF || out_coeff_value == -32'sh8000_0000, "saturated value not at a limit")

endmodule

bind ascii_decimal_to_fixed_point adtf_sva #(
  .NUM_COEFFS (NUM_COEFFS)
) u_adtf_checker (.*);
